// ----- rtl/b64_pkg.sv -----
// Package for the base64 stream codec: result and message state types,
// alphabet constants and the character conversion functions.
// No dependencies.
`timescale 1ns / 1ps

package b64_pkg;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Register index of the mode register.
  localparam logic [0:0] REG_MODE = 1'b0;

  localparam logic [0:0] MODE_ENCODE = 1'b0;
  localparam logic [0:0] MODE_DECODE = 1'b1;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2b;
  localparam logic [7:0] CHAR_SLASH   = 8'h2f;
  localparam logic [7:0] CHAR_NUL     = 8'h00;

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       bad;
    logic       last;
  } b64_res_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [2:0] held;
    logic       stopped;
    logic       err;
  } b64_state_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } b64_sextet_t;

  typedef struct packed {
    logic       mode;
    logic       clear;
  } b64_ctrl_t;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = CHAR_UPPER_A + {2'b00, v};
    end else if (v < 6'd52) begin
      c = CHAR_LOWER_A + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = CHAR_ZERO + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

  function automatic b64_sextet_t char_to_sextet(input logic [7:0] c);
    b64_sextet_t s;
    s.valid = 1'b1;
    s.value = 6'd0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      s.value = 6'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      s.value = 6'(c - CHAR_LOWER_A) + 6'd26;
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      s.value = 6'(c - CHAR_ZERO) + 6'd52;
    end else if (c == CHAR_PLUS) begin
      s.value = 6'd62;
    end else if (c == CHAR_SLASH) begin
      s.value = 6'd63;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

endpackage

// ----- rtl/base64_stream_codec.sv -----
// Unpadded base64 stream codec. An accepted item sits in the input register;
// its first result then moves to the output register once that is free.
// Items with at most one result go at one per cycle while the output is not
// stalled; an encoded byte with two characters holds the input register
// until both pass the single output register. Reset is synchronous and
// clears mode, message state and all valid flags at once, with no clearing pass.
`timescale 1ns / 1ps

module base64_stream_codec
  import b64_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 has_data,
  output logic                 bad_char,
  output logic                 out_last
);

  b64_ctrl_t  ctrl;
  b64_state_t st;
  b64_state_t st_next;
  b64_res_t   res0;
  b64_res_t   res1;
  b64_res_t   res_sel;
  b64_res_t   ores;
  logic [1:0] count;
  logic       ir_valid;
  logic [7:0] ir_byte;
  logic       ir_last;
  logic       ph;
  logic       ovalid;
  logic       out_load;
  logic       emit;
  logic       consume;

  b64_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctrl    (ctrl)
  );

  b64_step u_step (
    .mode      (ctrl.mode),
    .st        (st),
    .item_byte (ir_byte),
    .item_last (ir_last),
    .count     (count),
    .res0      (res0),
    .res1      (res1),
    .st_next   (st_next)
  );

  // The held item leaves once its last result is loaded; an item with no
  // result leaves at once whatever the output side does.
  assign out_load = !ovalid || out_ready;
  assign emit     = ir_valid && out_load && (count != 2'd0);
  assign consume  = ir_valid &&
                    ((count == 2'd0) || (out_load && ((count == 2'd1) || ph)));
  assign res_sel  = ph ? res1 : res0;
  assign in_ready = !ir_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
      ph       <= 1'b0;
      ovalid   <= 1'b0;
      st       <= '0;
    end else begin
      if (in_ready) begin
        ir_valid <= in_valid;
      end
      if (consume) begin
        ph <= 1'b0;
      end else if (emit) begin
        ph <= 1'b1;
      end
      if (ctrl.clear) begin
        st <= '0;
      end else if (consume) begin
        st <= st_next;
      end
      if (out_load) begin
        ovalid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ir_byte <= in_byte;
      ir_last <= in_last;
    end
    if (emit) begin
      ores <= res_sel;
    end
  end

  assign out_valid = ovalid;
  assign out_byte  = ores.data;
  assign has_data  = ores.has_data;
  assign bad_char  = ores.bad;
  assign out_last  = ores.last;

  // The second-result phase only exists for a held item with two results.
  a_phase_two: assert property (@(posedge clk) disable iff (rst)
    ph |-> (ir_valid && (count == 2'd2)))
    else $error("second-result phase without a two-result item");

  // An empty result is either an error report or the end of a message.
  a_empty_res: assert property (@(posedge clk) disable iff (rst)
    (ovalid && !ores.has_data) |-> ((ores.bad || ores.last) && (ores.data == 8'h00)))
    else $error("empty result that is neither bad nor last");

  // The last item of a message leaves no message state behind.
  a_last_clear: assert property (@(posedge clk) disable iff (rst)
    (consume && ir_last) |=> (st == '0))
    else $error("message state not cleared after last item");

  // Message state only changes when an item leaves or on a mode write.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    (!consume && !ctrl.clear) |=> $stable(st))
    else $error("message state changed without a transfer");

endmodule

// ----- rtl/b64_regs.sv -----
// APB register block of the base64 stream codec: the mode register.
// Depends on b64_pkg.
`timescale 1ns / 1ps

module b64_regs
  import b64_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready,
  output b64_ctrl_t            ctrl
);

  logic mode;
  logic clear;
  logic wr_en;
  logic sel_mode;

  assign pready   = 1'b1;
  assign sel_mode = (paddr[PADDR_W-1] == REG_MODE);
  assign wr_en    = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_ENCODE;
      clear <= 1'b0;
    end else begin
      clear <= 1'b0;
      if (wr_en && sel_mode) begin
        mode  <= pwdata[0];
        clear <= 1'b1;
      end
    end
  end

  assign prdata = sel_mode ? {{(PDATA_W-1){1'b0}}, mode} : '0;

  // A mode write also clears the message state in the cycle after the write;
  // the user makes it only while the block is idle; the block does not check.
  assign ctrl.mode  = mode;
  assign ctrl.clear = clear;

endmodule

// ----- rtl/b64_step.sv -----
// Per-item datapath of the base64 stream codec: up to two results and the
// next message state from the held item and the current state.
// Depends on b64_pkg.
`timescale 1ns / 1ps

module b64_step
  import b64_pkg::*;
(
  input  logic       mode,
  input  b64_state_t st,
  input  logic [7:0] item_byte,
  input  logic       item_last,
  output logic [1:0] count,
  output b64_res_t   res0,
  output b64_res_t   res1,
  output b64_state_t st_next
);

  logic [2:0]   h;
  logic [5:0]   pend;
  logic [13:0]  enc_comb;
  logic [3:0]   enc_total;
  logic [3:0]   enc_rem;
  logic [13:0]  enc_sh0;
  logic [13:0]  enc_sh1;
  logic [5:0]   flush_bits;
  logic         flush_en;
  logic [1:0]   enc_full;
  logic [11:0]  dec_comb;
  logic [3:0]   dec_total;
  logic [3:0]   dec_rem;
  logic [11:0]  dec_sh;
  b64_sextet_t  sx;
  b64_res_t     c0;
  b64_res_t     c1;
  b64_res_t     cf;

  always_comb begin
    h    = (st.held > 3'd6) ? 3'd6 : st.held;
    pend = st.acc[5:0] & 6'((7'd1 << h) - 7'd1);

    // Encode: six bits leave per character, oldest bits first.
    enc_comb  = {pend, item_byte};
    enc_total = {1'b0, h} + 4'd8;
    enc_sh0   = enc_comb >> (enc_total - 4'd6);
    enc_sh1   = enc_comb >> (enc_total - 4'd12);
    if (enc_total >= 4'd12) begin
      enc_full = 2'd2;
      enc_rem  = enc_total - 4'd12;
    end else begin
      enc_full = 2'd1;
      enc_rem  = enc_total - 4'd6;
    end
    flush_bits = enc_comb[5:0] << (4'd6 - enc_rem);
    flush_en   = item_last && (enc_rem != 4'd0) && (enc_full != 2'd2);

    c0 = '{data: sextet_to_char(enc_sh0[5:0]), has_data: 1'b1, bad: 1'b0, last: 1'b0};
    c1 = '{data: sextet_to_char(enc_sh1[5:0]), has_data: 1'b1, bad: 1'b0, last: 1'b0};
    cf = '{data: sextet_to_char(flush_bits), has_data: 1'b1, bad: 1'b0, last: 1'b0};

    // Decode: a byte leaves once eight bits have gathered.
    sx        = char_to_sextet(item_byte);
    dec_comb  = {pend, sx.value};
    dec_total = {1'b0, h} + 4'd6;
    dec_sh    = dec_comb >> (dec_total - 4'd8);
    dec_rem   = (dec_total >= 4'd8) ? dec_total - 4'd8 : dec_total;

    count   = 2'd0;
    res0    = '0;
    res1    = '0;
    st_next = st;

    if (mode == MODE_ENCODE) begin
      res0  = c0;
      res1  = (enc_full == 2'd2) ? c1 : cf;
      count = enc_full + {1'b0, flush_en};
      if (item_last) begin
        if (count == 2'd2) begin
          res1.last = 1'b1;
        end else begin
          res0.last = 1'b1;
        end
        st_next = '0;
      end else begin
        st_next.acc  = 8'(enc_comb & ((14'd1 << enc_rem) - 14'd1));
        st_next.held = enc_rem[2:0];
      end
    end else if (st.stopped || st.err) begin
      // The rest of the message is ignored until its last item.
      if (item_last) begin
        count   = 2'd1;
        res0    = '{data: 8'h00, has_data: 1'b0, bad: st.err, last: 1'b1};
        st_next = '0;
      end
    end else if (item_byte == CHAR_NUL) begin
      if (item_last) begin
        count   = 2'd1;
        res0    = '{data: 8'h00, has_data: 1'b0, bad: 1'b0, last: 1'b1};
        st_next = '0;
      end else begin
        st_next.stopped = 1'b1;
      end
    end else if (!sx.valid) begin
      count = 2'd1;
      res0  = '{data: 8'h00, has_data: 1'b0, bad: 1'b1, last: item_last};
      if (item_last) begin
        st_next = '0;
      end else begin
        st_next.err = 1'b1;
      end
    end else begin
      if (dec_total >= 4'd8) begin
        count = 2'd1;
        res0  = '{data: dec_sh[7:0], has_data: 1'b1, bad: 1'b0, last: item_last};
      end else if (item_last) begin
        count = 2'd1;
        res0  = '{data: 8'h00, has_data: 1'b0, bad: 1'b0, last: 1'b1};
      end
      if (item_last) begin
        st_next = '0;
      end else begin
        st_next.acc  = 8'(dec_comb & ((12'd1 << dec_rem) - 12'd1));
        st_next.held = dec_rem[2:0];
      end
    end
  end

endmodule

// ----- tb/sv/b64_codec_checker.sv -----
// Scoreboard for the base64 stream codec: watches the APB, input and output
// channels, predicts each result and compares it field by field.
// Depends on b64_pkg for the result type, mode codes and character constants.
`timescale 1ns / 1ps

module b64_codec_checker
  import b64_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [7:0]         out_byte,
  input  logic               has_data,
  input  logic               bad_char,
  input  logic               out_last,
  output int                 mismatches,
  output int                 outstanding
);

  localparam logic [PADDR_W-1:0] MODE_ADDR = PADDR_W'(4 * REG_MODE);

  string glyphs = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic       mode_q;
  logic [7:0] acc_q;
  logic [2:0] held_q;
  logic       halted_q;
  logic       faulted_q;
  b64_res_t   codec_results[$];

  function automatic int sextet_of(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (glyphs[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic b64_res_t result_of(input logic [7:0] d, input logic h, input logic b,
                                         input logic l);
    b64_res_t r;
    r.data     = d;
    r.has_data = h;
    r.bad      = b;
    r.last     = l;
    return r;
  endfunction

  task automatic clear_message_state();
    acc_q     = '0;
    held_q    = '0;
    halted_q  = 1'b0;
    faulted_q = 1'b0;
  endtask

  // Works out the results of one accepted input transfer and queues them.
  task automatic predict_codec(input logic [7:0] b, input logic l);
    logic [13:0]  bits;
    int unsigned  count;
    int           value;
    int unsigned  made;
    b64_res_t     made_res [2];
    count = (held_q > 3'd6) ? 6 : held_q;
    bits  = 14'(acc_q) & ((14'd1 << count) - 14'd1);
    made  = 0;
    if (mode_q == MODE_ENCODE) begin
      bits  = (bits << 8) | 14'(b);
      count = count + 8;
      while (count >= 6 && made < 2) begin
        count = count - 6;
        made_res[made] = result_of(glyphs[6'(bits >> count)], 1'b1, 1'b0, 1'b0);
        made++;
      end
      bits = bits & ((14'd1 << count) - 14'd1);
      if (l) begin
        // Leftover bits are padded with zeros up to a whole character.
        if (count > 0 && made < 2) begin
          made_res[made] = result_of(glyphs[6'(bits << (6 - count))], 1'b1, 1'b0, 1'b0);
          made++;
        end
        made_res[made - 1].last = 1'b1;
        clear_message_state();
      end else begin
        acc_q  = 8'(bits);
        held_q = 3'(count);
      end
    end else if (halted_q || faulted_q) begin
      if (l) begin
        made_res[0] = result_of(8'h00, 1'b0, faulted_q, 1'b1);
        made = 1;
        clear_message_state();
      end
    end else if (b == CHAR_NUL) begin
      if (l) begin
        made_res[0] = result_of(8'h00, 1'b0, 1'b0, 1'b1);
        made = 1;
        clear_message_state();
      end else begin
        halted_q = 1'b1;
      end
    end else begin
      value = sextet_of(b);
      if (value < 0) begin
        made_res[0] = result_of(8'h00, 1'b0, 1'b1, l);
        made = 1;
        if (l) clear_message_state();
        else faulted_q = 1'b1;
      end else begin
        bits  = (bits << 6) | 14'(value);
        count = count + 6;
        if (count >= 8) begin
          count = count - 8;
          made_res[0] = result_of(8'(bits >> count), 1'b1, 1'b0, l);
          made = 1;
          bits = bits & ((14'd1 << count) - 14'd1);
        end else if (l) begin
          made_res[0] = result_of(8'h00, 1'b0, 1'b0, 1'b1);
          made = 1;
        end
        if (l) begin
          clear_message_state();
        end else begin
          acc_q  = 8'(bits);
          held_q = 3'(count);
        end
      end
    end
    for (int unsigned i = 0; i < made; i++) codec_results.push_back(made_res[i]);
  endtask

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s wrong, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    b64_res_t want;
    if (rst) begin
      mode_q = MODE_ENCODE;
      clear_message_state();
      codec_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (codec_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h/%b/%b/%b", $time,
                   out_byte, has_data, bad_char, out_last);
          mismatches++;
        end else begin
          want = codec_results.pop_front();
          compare_field("out_byte", want.data, out_byte);
          compare_field("has_data", 8'(want.has_data), 8'(has_data));
          compare_field("bad_char", 8'(want.bad), 8'(bad_char));
          compare_field("out_last", 8'(want.last), 8'(out_last));
        end
      end
      // A mode write also throws away any part-finished message.
      if (psel && penable && pwrite && pready && paddr == MODE_ADDR) begin
        mode_q = pwdata[0];
        clear_message_state();
      end
      if (in_valid && in_ready) predict_codec(in_byte, in_last);
    end
    outstanding = codec_results.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the base64 stream codec testbench: clock, reset, APB mode writes,
// input and output stimulus with random idling, and the final verdict.
// Depends on b64_pkg, base64_stream_codec and b64_codec_checker.
`timescale 1ns / 1ps

module testbench;
  import b64_pkg::*;

  localparam int unsigned ITEM_TARGET = 1850;
  localparam int unsigned CALM_FROM   = 1650;
  localparam logic [PADDR_W-1:0] MODE_ADDR = PADDR_W'(4 * REG_MODE);
  localparam logic [7:0] CHAR_PAD = 8'h3d;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_byte;
  logic               in_last;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         out_byte;
  logic               has_data;
  logic               bad_char;
  logic               out_last;
  int                 mismatches;
  int                 outstanding;
  int unsigned        items_sent = 0;
  logic               calm = 1'b0;

  base64_stream_codec uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .has_data(has_data), .bad_char(bad_char), .out_last(out_last)
  );

  b64_codec_checker scoreboard (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .has_data(has_data), .bad_char(bad_char), .out_last(out_last),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: alternating bursts of ready and stall, with no stalls near the end.
  initial begin
    int unsigned burst;
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        burst = $urandom_range(1, 16);
      end else begin
        out_ready <= 1'b1;
        burst = $urandom_range(1, 32);
      end
      repeat (burst) @(posedge clk);
    end
  end

  // Presents one item and holds it until the transfer; may then idle.
  task automatic send_item(input logic [7:0] b, input logic l, input bit counts);
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (counts) items_sent++;
    if (items_sent >= CALM_FROM) calm = 1'b1;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Waits until every predicted result has arrived, plus the pipeline depth,
  // so that items which produce nothing have also drained.
  task automatic settle_codec();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= PDATA_W'(m);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] random_glyph();
    case ($urandom_range(0, 4))
      0, 1:    return CHAR_UPPER_A + 8'($urandom_range(0, 25));
      2:       return CHAR_LOWER_A + 8'($urandom_range(0, 25));
      3:       return CHAR_ZERO + 8'($urandom_range(0, 9));
      default: return $urandom_range(0, 1) ? CHAR_PLUS : CHAR_SLASH;
    endcase
  endfunction

  // Characters outside the alphabet: padding, top-bit bytes, and control
  // characters or punctuation below the plus sign.
  function automatic logic [7:0] random_stray();
    case ($urandom_range(0, 2))
      0:       return CHAR_PAD;
      1:       return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(1, 42));
    endcase
  endfunction

  function automatic int unsigned random_length();
    return ($urandom_range(0, 6) == 0) ? $urandom_range(11, 48) : $urandom_range(1, 10);
  endfunction

  task automatic send_encode_message(input int unsigned len, input logic closed);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(8'($urandom_range(0, 255)), closed && i == len - 1, 1'b1);
    end
  endtask

  // Mostly well-formed text; some messages are cut short by a zero character
  // or a stray one, and a few are pure noise. Items after the cut are ignored
  // by the codec and so are not counted.
  task automatic send_decode_message(input int unsigned len, input logic closed);
    int unsigned kind;
    int unsigned flaw_at;
    logic        dead;
    logic [7:0]  c;
    kind    = $urandom_range(0, 99);
    flaw_at = (kind < 80) ? len : $urandom_range(0, len - 1);
    dead    = 1'b0;
    for (int unsigned i = 0; i < len; i++) begin
      if (kind >= 92) c = 8'($urandom_range(0, 255));
      else if (i == flaw_at) c = (kind < 86) ? CHAR_NUL : random_stray();
      else c = random_glyph();
      send_item(c, closed && i == len - 1, !dead);
      if (kind >= 92 || i == flaw_at) dead = 1'b1;
    end
  endtask

  initial begin
    logic        m;
    int unsigned msgs;
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    in_valid <= 1'b0;
    in_byte  <= '0;
    in_last  <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Encoding. The first byte leaves two bits behind, which the mode write
    // must discard before the zero byte that follows.
    send_item(8'h41, 1'b0, 1'b1);
    settle_codec();
    write_mode(MODE_ENCODE);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'hfb, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    settle_codec();

    // Decoding: a lone character, the alphabet's edges, a stop mid-message,
    // a stop as the final item, a stray character mid-message and at the end.
    write_mode(MODE_DECODE);
    send_item(CHAR_UPPER_A, 1'b1, 1'b1);
    send_item(CHAR_UPPER_Z, 1'b0, 1'b1);
    send_item(CHAR_LOWER_Z, 1'b0, 1'b1);
    send_item(CHAR_ZERO, 1'b0, 1'b1);
    send_item(CHAR_NINE, 1'b0, 1'b1);
    send_item(CHAR_PLUS, 1'b0, 1'b1);
    send_item(CHAR_SLASH, 1'b1, 1'b1);
    send_item("Q", 1'b0, 1'b1);
    send_item(CHAR_NUL, 1'b0, 1'b1);
    send_item("W", 1'b0, 1'b0);
    send_item("E", 1'b1, 1'b0);
    send_item("Q", 1'b0, 1'b1);
    send_item("Q", 1'b0, 1'b1);
    send_item(CHAR_NUL, 1'b1, 1'b1);
    send_item("Q", 1'b0, 1'b1);
    send_item(CHAR_PAD, 1'b0, 1'b1);
    send_item("Q", 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    settle_codec();

    while (items_sent < ITEM_TARGET) begin
      m = 1'($urandom_range(0, 1));
      write_mode(m);
      msgs = $urandom_range(1, 8);
      for (int unsigned k = 0; k < msgs; k++) begin
        // Now and then the phase ends part-way through a message.
        if (m == MODE_ENCODE) begin
          send_encode_message(random_length(), k + 1 < msgs || $urandom_range(0, 7) != 0);
        end else begin
          send_decode_message(random_length(), k + 1 < msgs || $urandom_range(0, 7) != 0);
        end
      end
      settle_codec();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
